### sv/discrete_accel_profile_step_macros.svh
// Assertion macros used by the checker of this block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DISCRETE_ACCEL_PROFILE_STEP_MACROS_SVH
`define DISCRETE_ACCEL_PROFILE_STEP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define DAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define DAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dap_pkg.sv
package dap_pkg;

    // Iteration guard of the acceleration reduction loop
    localparam int MAX_ITER = 65536;

    // Field widths
    localparam int DIST_W  = 32;
    localparam int VEL_W   = 16;
    localparam int ACCO_W  = 17;
    localparam int VMAX_W  = 15;
    localparam int AMAX_W  = 12;
    localparam int CFG_D_W = 16;
    localparam int CFG_I_W = 1;

    // Internal widths, derived from the guard
    localparam int STEP_W  = $clog2(MAX_ITER + 1);
    localparam int ACC_W   = $clog2(MAX_ITER + 65536) + 2;
    localparam int SV_W    = ACC_W + 1;
    localparam int MAG_W   = SV_W;
    localparam int PROD_W  = 2 * (MAG_W + 1);
    localparam int SUM_W   = PROD_W + 2;
    localparam int DCNT_W  = $clog2(MAG_W + 1);

    // Register reset values
    localparam logic [VMAX_W-1:0] VMAX_RESET = VMAX_W'(1000);
    localparam logic [AMAX_W-1:0] AMAX_RESET = AMAX_W'(10);

    // Register indexes
    localparam logic [CFG_I_W-1:0] CFG_MAX_VELOCITY = 1'b0;
    localparam logic [CFG_I_W-1:0] CFG_MAX_ACCEL    = 1'b1;

    // Direction codes
    localparam logic signed [1:0] DIR_ZERO = 2'sd0;
    localparam logic signed [1:0] DIR_POS  = 2'sd1;
    localparam logic signed [1:0] DIR_NEG  = -2'sd1;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic signed [VEL_W-1:0]  velocity;
        logic signed [VEL_W-1:0]  goal_velocity;
    } t_in_beat;

    typedef struct packed {
        logic signed [ACCO_W-1:0] accel;
        logic                     hit_limit;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_GDIV,
        ST_GMUL,
        ST_GSTORE,
        ST_VDIV,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_dap_state;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic overshoot;
        logic at_limit;
        logic out_free;
    } t_dap_status;

    // Sequencer controls for the datapath
    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic init;
        logic div_go;
        logic div_goal;
        logic mul_en;
        logic mul_goal;
        logic gb_load;
        logic loop_load;
        logic step;
        logic set_limit;
        logic finish;
    } t_dap_ctrl;

endpackage

### sv/dap_div.sv
// Restoring divider, one quotient bit per cycle
module dap_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dap_pkg::MAG_W-1:0]   i_num,
    input  logic [dap_pkg::AMAX_W-1:0]  i_den,
    output logic [dap_pkg::MAG_W-1:0]   o_quo,
    output logic [dap_pkg::AMAX_W-1:0]  o_rem,
    output logic                        o_done
);

    logic [dap_pkg::MAG_W-1:0]  r_num;
    logic [dap_pkg::AMAX_W-1:0] r_rem;
    logic [dap_pkg::AMAX_W-1:0] r_den;
    logic [dap_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_done;
    logic [dap_pkg::AMAX_W:0]   trial;
    logic                       ge;

    // Trial subtract of the next partial remainder
    always_comb begin
        trial = {r_rem, r_num[dap_pkg::MAG_W-1]};
        ge    = (trial >= {1'b0, r_den});
    end

    // Counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= dap_pkg::DCNT_W'(dap_pkg::MAG_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == dap_pkg::DCNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Shift register: numerator bits out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[dap_pkg::MAG_W-2:0], ge};
            r_rem <= ge ? dap_pkg::AMAX_W'(trial - {1'b0, r_den})
                        : trial[dap_pkg::AMAX_W-1:0];
        end
    end

    assign o_quo  = r_num;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### sv/dap_fsm.sv
// Sequencer: goal braking distance, loop setup, reduction loop, result
module dap_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dap_pkg::t_dap_status i_status,
    output dap_pkg::t_dap_ctrl   o_ctrl
);

    dap_pkg::t_dap_state r_state;
    dap_pkg::t_dap_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dap_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            dap_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state        = dap_pkg::ST_INIT;
                end
            end
            // pick start accel, start |goal| / amax
            dap_pkg::ST_INIT: begin
                o_ctrl.init     = 1'b1;
                o_ctrl.div_go   = 1'b1;
                o_ctrl.div_goal = 1'b1;
                n_state         = dap_pkg::ST_GDIV;
            end
            dap_pkg::ST_GDIV: begin
                if (i_status.div_done) begin
                    n_state = dap_pkg::ST_GMUL;
                end
            end
            dap_pkg::ST_GMUL: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_goal = 1'b1;
                n_state         = dap_pkg::ST_GSTORE;
            end
            // store goal term, start |v + accel| / amax
            dap_pkg::ST_GSTORE: begin
                o_ctrl.gb_load = 1'b1;
                o_ctrl.div_go  = 1'b1;
                n_state        = dap_pkg::ST_VDIV;
            end
            dap_pkg::ST_VDIV: begin
                if (i_status.div_done) begin
                    o_ctrl.loop_load = 1'b1;
                    n_state          = dap_pkg::ST_MUL;
                end
            end
            dap_pkg::ST_MUL: begin
                o_ctrl.mul_en = 1'b1;
                n_state       = dap_pkg::ST_CMP;
            end
            // overshoot test, then one reduction step or stop
            dap_pkg::ST_CMP: begin
                if (!i_status.overshoot) begin
                    n_state = dap_pkg::ST_DONE;
                end else if (i_status.at_limit) begin
                    o_ctrl.set_limit = 1'b1;
                    n_state          = dap_pkg::ST_DONE;
                end else begin
                    o_ctrl.step = 1'b1;
                    n_state     = dap_pkg::ST_MUL;
                end
            end
            dap_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = dap_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/discrete_accel_profile_step.sv
// Discrete trapezoidal profile: acceleration for one timestep.
// Input channel (i_in_valid / o_in_ready, i_in_beat): distance to target,
// current velocity and goal velocity. Output channel (o_out_valid /
// i_out_ready, o_out_beat): chosen accel, saturated to 17 bits, and
// hit_limit when the reduction loop ran into its iteration guard.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 max_velocity, index 1 max_accel; always ready; writes must come only idle, left unenforced by the block.
// The result beat follows two passes of the bit-serial divider, then one
// pass through the shared multiplier and the overshoot compare for each
// loop test, with 0..MAX_ITER reduction steps before the stop.
// One item is worked at a time; o_in_ready is high only while idle.
// A finished result sits in the output register; the next beat is taken
// while it waits. If the receiver stalls with a result still held, the
// following result waits in the sequencer until that register frees up.
// Reset clears the sequencer and output valid and loads max_velocity 1000
// and max_accel 10. A max_accel of zero acts as one.
module discrete_accel_profile_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dap_pkg::t_in_beat                 i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dap_pkg::t_out_beat                o_out_beat,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dap_pkg::CFG_I_W-1:0]       i_cfg_index,
    input  logic [dap_pkg::CFG_D_W-1:0]       i_cfg_data
);

    localparam int ACC_W  = dap_pkg::ACC_W;
    localparam int SV_W   = dap_pkg::SV_W;
    localparam int MAG_W  = dap_pkg::MAG_W;
    localparam int PROD_W = dap_pkg::PROD_W;
    localparam int SUM_W  = dap_pkg::SUM_W;
    localparam int AW     = dap_pkg::AMAX_W;
    localparam int ACCO_SAT_W = dap_pkg::ACCO_W;

    dap_pkg::t_dap_ctrl   ctrl;
    dap_pkg::t_dap_status status;

    // Config registers
    logic [dap_pkg::VMAX_W-1:0] r_cfg_vmax;
    logic [AW-1:0]              r_cfg_amax;
    logic [AW-1:0]              amax_eff;

    // Item registers
    dap_pkg::t_in_beat          r_in;
    logic signed [1:0]          r_dir;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SUM_W-1:0]    r_base;
    logic signed [SV_W-1:0]     r_sv;
    logic [MAG_W-1:0]           r_m;
    logic [MAG_W-1:0]           r_q;
    logic [AW-1:0]              r_r;
    logic [dap_pkg::STEP_W-1:0] r_steps;
    logic                       r_limit;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_ovalid;
    dap_pkg::t_out_beat         r_obeat;

    // Start selection signals
    logic signed [32:0]         dist_x;
    logic signed [12:0]         amax_s;
    logic signed [15:0]         vmax_s;
    logic signed [1:0]          dir0;
    logic signed [18:0]         dv;
    logic signed [16:0]         vg;
    logic                       c1, c2, c3;
    logic signed [ACC_W-1:0]    a1, a2, a3, a4;
    logic signed [ACC_W-1:0]    acc0;
    logic signed [1:0]          dir_start;

    // Divider and multiplier signals
    logic [16:0]                goal_mag;
    logic signed [SV_W-1:0]     sv0;
    logic [MAG_W-1:0]           sv_mag;
    logic [MAG_W-1:0]           div_num;
    logic [MAG_W-1:0]           div_quo;
    logic [AW-1:0]              div_rem;
    logic                       div_done;
    logic [MAG_W:0]             mul_a;
    logic [MAG_W:0]             mul_b;
    logic [PROD_W-1:0]          prod;

    // Braking distance and loop test
    logic signed [SUM_W-1:0]    half_s;
    logic signed [SUM_W-1:0]    bd;
    logic signed [SUM_W-1:0]    gbv;
    logic signed [SUM_W-1:0]    tsum;
    logic                       overshoot;
    logic                       mag_dec;
    logic signed [ACCO_SAT_W-1:0] acc_sat;

    assign o_cfg_ready = 1'b1;
    assign amax_eff    = (r_cfg_amax == '0) ? AW'(1) : r_cfg_amax;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_vmax <= dap_pkg::VMAX_RESET;
            r_cfg_amax <= dap_pkg::AMAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dap_pkg::CFG_MAX_VELOCITY: r_cfg_vmax <= i_cfg_data[dap_pkg::VMAX_W-1:0];
                dap_pkg::CFG_MAX_ACCEL:    r_cfg_amax <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // Starting acceleration: velocity cap, settle, near target, full accel
    always_comb begin
        dist_x = 33'(r_in.distance);
        amax_s = $signed({1'b0, amax_eff});
        vmax_s = $signed({1'b0, r_cfg_vmax});
        if (r_in.distance > 0) begin
            dir0 = dap_pkg::DIR_POS;
        end else if (r_in.distance < 0) begin
            dir0 = dap_pkg::DIR_NEG;
        end else begin
            dir0 = dap_pkg::DIR_ZERO;
        end
        if (dir0 == dap_pkg::DIR_POS) begin
            dv = 19'(r_in.velocity);
            a1 = ACC_W'(vmax_s) - ACC_W'(r_in.velocity);
            a4 = ACC_W'(amax_s);
        end else if (dir0 == dap_pkg::DIR_NEG) begin
            dv = -19'(r_in.velocity);
            a1 = -ACC_W'(vmax_s) - ACC_W'(r_in.velocity);
            a4 = -ACC_W'(amax_s);
        end else begin
            dv = 19'sd0;
            a1 = -ACC_W'(r_in.velocity);
            a4 = ACC_W'(0);
        end
        vg = 17'(r_in.velocity) - 17'(r_in.goal_velocity);
        c1 = (dv + 19'(amax_s)) > 19'(vmax_s);
        c2 = (r_in.distance == 0) && (vg <= 17'(amax_s)) && (vg >= -17'(amax_s));
        c3 = (dist_x <= 33'(amax_s)) && (dist_x >= -33'(amax_s));
        a2 = ACC_W'(r_in.goal_velocity) - ACC_W'(r_in.velocity);
        a3 = ACC_W'(dist_x - 33'(r_in.velocity));
        dir_start = dir0;
        if (c1) begin
            acc0 = a1;
        end else if (c2) begin
            acc0 = a2;
            if (a2 > 0) begin
                dir_start = dap_pkg::DIR_POS;
            end else if (a2 < 0) begin
                dir_start = dap_pkg::DIR_NEG;
            end else begin
                dir_start = dap_pkg::DIR_ZERO;
            end
        end else if (c3) begin
            acc0 = a3;
        end else begin
            acc0 = a4;
        end
    end

    // Divider numerator: |goal| or |v + accel|
    always_comb begin
        goal_mag = r_in.goal_velocity[dap_pkg::VEL_W-1]
                 ? 17'(-17'(r_in.goal_velocity)) : 17'(r_in.goal_velocity);
        sv0      = SV_W'(r_in.velocity) + SV_W'(r_acc);
        sv_mag   = sv0[SV_W-1] ? MAG_W'(-sv0) : MAG_W'(sv0);
        div_num  = ctrl.div_goal ? MAG_W'(goal_mag) : sv_mag;
    end

    dap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.div_go),
        .i_num   (div_num),
        .i_den   (amax_eff),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_done  (div_done)
    );

    // Shared multiplier: (q + 1) * (m + r), braking distance is half of it
    always_comb begin
        if (ctrl.mul_goal) begin
            mul_a = (MAG_W + 1)'(div_quo) + 1'b1;
            mul_b = (MAG_W + 1)'(goal_mag) + (MAG_W + 1)'(div_rem);
        end else begin
            mul_a = (MAG_W + 1)'(r_q) + 1'b1;
            mul_b = (MAG_W + 1)'(r_m) + (MAG_W + 1)'(r_r);
        end
        prod = mul_a * mul_b;
    end

    // Overshoot test of the current accel
    always_comb begin
        half_s  = SUM_W'($signed({1'b0, r_prod[PROD_W-1:1]}));
        bd      = r_sv[SV_W-1] ? -half_s : half_s;
        gbv     = r_in.goal_velocity[dap_pkg::VEL_W-1] ? -half_s : half_s;
        tsum    = bd + r_base;
        if (r_dir == dap_pkg::DIR_POS) begin
            overshoot = (tsum > 0);
        end else if (r_dir == dap_pkg::DIR_NEG) begin
            overshoot = (tsum < 0);
        end else begin
            overshoot = 1'b0;
        end
        mag_dec = ((r_dir == dap_pkg::DIR_POS) && (r_sv > 0))
               || ((r_dir == dap_pkg::DIR_NEG) && (r_sv < 0));
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        if (ctrl.load_in) begin
            r_in <= i_in_beat;
        end
        if (ctrl.init) begin
            r_acc   <= acc0;
            r_dir   <= dir_start;
            r_steps <= '0;
            r_limit <= 1'b0;
        end
        if (ctrl.mul_en) begin
            r_prod <= prod;
        end
        if (ctrl.gb_load) begin
            r_base <= SUM_W'(r_in.velocity) - gbv - SUM_W'(r_in.distance);
        end
        if (ctrl.loop_load) begin
            r_sv <= sv0;
            r_m  <= sv_mag;
            r_q  <= div_quo;
            r_r  <= div_rem;
        end
        if (ctrl.set_limit) begin
            r_limit <= 1'b1;
        end
        // one reduction step: accel and v + accel move against direction
        if (ctrl.step) begin
            r_acc   <= r_acc - ACC_W'(r_dir);
            r_sv    <= r_sv - SV_W'(r_dir);
            r_steps <= r_steps + 1'b1;
            if (mag_dec) begin
                r_m <= r_m - 1'b1;
                if (r_r == '0) begin
                    r_r <= amax_eff - 1'b1;
                    r_q <= r_q - 1'b1;
                end else begin
                    r_r <= r_r - 1'b1;
                end
            end else begin
                r_m <= r_m + 1'b1;
                if (r_r == amax_eff - 1'b1) begin
                    r_r <= '0;
                    r_q <= r_q + 1'b1;
                end else begin
                    r_r <= r_r + 1'b1;
                end
            end
        end
    end

    // Saturate accel to the output field
    always_comb begin
        if (r_acc > ACC_W'(65535)) begin
            acc_sat = ACCO_SAT_W'(65535);
        end else if (r_acc < ACC_W'(-65536)) begin
            acc_sat = ACCO_SAT_W'(-65536);
        end else begin
            acc_sat = r_acc[ACCO_SAT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.finish) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.finish) begin
            r_obeat.accel     <= acc_sat;
            r_obeat.hit_limit <= r_limit;
        end
    end

    // Sequencer
    always_comb begin
        status.in_valid  = i_in_valid;
        status.div_done  = div_done;
        status.overshoot = overshoot;
        status.at_limit  = (r_steps == dap_pkg::STEP_W'(dap_pkg::MAX_ITER));
        status.out_free  = !r_ovalid || i_out_ready;
    end

    dap_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

endmodule

### sv/dap_checker.sv
`include "discrete_accel_profile_step_macros.svh"

// Port-level checks of the profile step block
module dap_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dap_pkg::t_out_beat o_out_beat
);

    // block goes busy once it takes a beat
    `DAP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")

    // a new result appears together with the return to idle
    `DAP_ASSERT_NOW(a_result_with_idle, $rose(o_out_valid), o_in_ready, "result while busy")

    // stalled result stays
    `DAP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    // stalled result keeps its payload
    `DAP_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_beat), "result changed")

endmodule

bind discrete_accel_profile_step dap_checker u_dap_checker (.*);
